FILE: rtl/cbf_pkg.sv
// shared types, constants and helpers for the contour box filter
package cbf_pkg;

    localparam int COORD_BITS   = 12;
    localparam int ASPECT_LIMIT = 2;
    localparam int EDGE_MARGIN  = 10;

    localparam int CFG_DIM_W  = 12;
    localparam int CFG_AREA_W = 24;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = CFG_AREA_W;

    localparam int AREA_W = 2 * COORD_BITS;
    localparam int CMP_W  = ((AREA_W > CFG_AREA_W) ? AREA_W : CFG_AREA_W) + 2;

    localparam int IN_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int VERDICT_W  = 3;
    localparam int CHECK_W    = 4;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic signed [CMP_W-1:0] t_cmp;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 4'd0,
        REG_IMAGE_HEIGHT = 4'd1,
        REG_MIN_AREA     = 4'd2,
        REG_MAX_AREA     = 4'd3,
        REG_ROI_LEFT     = 4'd4,
        REG_ROI_TOP      = 4'd5,
        REG_ROI_WIDTH    = 4'd6,
        REG_ROI_HEIGHT   = 4'd7
    } t_reg_idx;

    typedef enum logic [VERDICT_W-1:0] {
        V_KEPT    = 3'd0,
        V_SMALL   = 3'd1,
        V_LARGE   = 3'd2,
        V_ELONG   = 3'd3,
        V_BORDER  = 3'd4,
        V_OUTSIDE = 3'd5
    } t_verdict;

    // one test per code, run in this order; first failing test decides
    typedef enum logic [CHECK_W-1:0] {
        CK_SMALL         = 4'd0,
        CK_LARGE         = 4'd1,
        CK_WIDE          = 4'd2,
        CK_TALL          = 4'd3,
        CK_LEFT_EDGE     = 4'd4,
        CK_TOP_EDGE      = 4'd5,
        CK_RIGHT_EDGE    = 4'd6,
        CK_BOTTOM_EDGE   = 4'd7,
        CK_ROI_LEFT      = 4'd8,
        CK_ROI_TOP       = 4'd9,
        CK_ROI_RIGHT     = 4'd10,
        CK_ROI_BOTTOM    = 4'd11
    } t_check;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIZE,
        ST_AREA,
        ST_CHECK,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [CFG_DIM_W-1:0]  image_width;
        logic [CFG_DIM_W-1:0]  image_height;
        logic [CFG_AREA_W-1:0] min_area;
        logic [CFG_AREA_W-1:0] max_area;
        logic [CFG_DIM_W-1:0]  roi_left;
        logic [CFG_DIM_W-1:0]  roi_top;
        logic [CFG_DIM_W-1:0]  roi_width;
        logic [CFG_DIM_W-1:0]  roi_height;
    } t_cfg;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord w;
        t_coord h;
    } t_box;

    localparam t_cfg CFG_RESET = '{
        image_width:  CFG_DIM_W'(640),
        image_height: CFG_DIM_W'(480),
        min_area:     CFG_AREA_W'(10),
        max_area:     CFG_AREA_W'(4000),
        roi_left:     CFG_DIM_W'(0),
        roi_top:      CFG_DIM_W'(0),
        roi_width:    CFG_DIM_W'(640),
        roi_height:   CFG_DIM_W'(480)
    };

    function automatic t_verdict check_verdict(t_check ck);
        t_verdict v;
        case (ck) inside
            CK_SMALL:                                       v = V_SMALL;
            CK_LARGE:                                       v = V_LARGE;
            CK_WIDE, CK_TALL:                               v = V_ELONG;
            CK_LEFT_EDGE, CK_TOP_EDGE, CK_RIGHT_EDGE,
            CK_BOTTOM_EDGE:                                 v = V_BORDER;
            default:                                        v = V_OUTSIDE;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/contour_box_filter.sv
// top level: contour bounding box tracker with sequenced keep/reject tests
//
// Contour points arrive on the slave stream; each beat carries one point and
// tlast marks the final point of a contour. A point without tlast only
// updates the running min/max of x and y. A point with tlast closes the
// box (corner = minima, size = maxima minus minima, never negative) and
// restarts the running values: minima from the image size registers,
// maxima at zero. The box then goes through size, area and up to twelve
// tests on one shared compare unit, one test per cycle, stopping at the
// first that fails: too small, too large, elongated (side at least
// ASPECT_LIMIT+1 times the other, so a flat box counts as elongated), at the
// image border margin, outside the region of interest. After a last point
// tready stays low through the size, area, test and finish states, so the
// wait before the next accepted point grows with the number of tests the
// compare unit has to step through; the finish state repeats for as long as
// the previous box still sits unread in the output register. The master
// stream carries the box in tdata and the verdict in tuser. Registers are
// written through the config channel, which is always ready; write them
// only while no contour is in flight. Indexes beyond the list are ignored.
module contour_box_filter (
    input  logic i_clk,
    input  logic i_rst_n,

    // point stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [cbf_pkg::IN_DATA_W-1:0] i_s_tdata,   // point_x, point_y
    input  logic                          i_s_tlast,   // last_point

    // box stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [cbf_pkg::OUT_DATA_W-1:0] o_m_tdata,  // box_left, box_top, box_width, box_height
    output logic [cbf_pkg::VERDICT_W-1:0]  o_m_tuser,  // verdict

    // register writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cbf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cbf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = cbf_pkg::COORD_BITS;

    cbf_pkg::t_state r_state, n_state;
    cbf_pkg::t_cfg   r_cfg;

    // running extrema of the current contour
    cbf_pkg::t_coord r_min_x, r_max_x, r_min_y, r_max_y;
    cbf_pkg::t_coord n_min_x, n_max_x, n_min_y, n_max_y;

    // closed box under test
    cbf_pkg::t_box   r_box;
    cbf_pkg::t_coord r_hi_x, r_hi_y;
    logic [cbf_pkg::AREA_W-1:0] r_area;
    cbf_pkg::t_check r_step;
    cbf_pkg::t_verdict r_verdict;

    // output register
    logic              r_out_valid;
    cbf_pkg::t_box     r_out_box;
    cbf_pkg::t_verdict r_out_verdict;

    cbf_pkg::t_coord s_px, s_py;
    logic s_in_beat, s_out_beat, s_fail, s_last_check, s_load_out;

    assign s_px = i_s_tdata[CW-1:0];
    assign s_py = i_s_tdata[2*CW-1:CW];

    assign s_in_beat    = i_s_tvalid && o_s_tready;
    assign s_out_beat   = r_out_valid && i_m_tready;
    assign s_last_check = (r_step == cbf_pkg::CK_ROI_BOTTOM);
    assign s_load_out   = (r_state == cbf_pkg::ST_FINISH) && (!r_out_valid || i_m_tready);

    // min/max update for the incoming point
    always_comb begin
        n_min_x = (s_px < r_min_x) ? s_px : r_min_x;
        n_max_x = (s_px > r_max_x) ? s_px : r_max_x;
        n_min_y = (s_py < r_min_y) ? s_py : r_min_y;
        n_max_y = (s_py > r_max_y) ? s_py : r_max_y;
    end

    cbf_judge u_judge (
        .i_check (r_step),
        .i_box   (r_box),
        .i_area  (r_area),
        .i_cfg   (r_cfg),
        .o_fail  (s_fail)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cbf_pkg::ST_IDLE: begin
                if (s_in_beat && i_s_tlast) n_state = cbf_pkg::ST_SIZE;
            end
            cbf_pkg::ST_SIZE:  n_state = cbf_pkg::ST_AREA;
            cbf_pkg::ST_AREA:  n_state = cbf_pkg::ST_CHECK;
            cbf_pkg::ST_CHECK: begin
                if (s_fail || s_last_check) n_state = cbf_pkg::ST_FINISH;
            end
            cbf_pkg::ST_FINISH: begin
                if (s_load_out) n_state = cbf_pkg::ST_IDLE;
            end
            default: n_state = cbf_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_s_tready = (r_state == cbf_pkg::ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // register file
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= cbf_pkg::CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                cbf_pkg::REG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg_data[cbf_pkg::CFG_DIM_W-1:0];
                cbf_pkg::REG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg_data[cbf_pkg::CFG_DIM_W-1:0];
                cbf_pkg::REG_MIN_AREA:     r_cfg.min_area     <= i_cfg_data[cbf_pkg::CFG_AREA_W-1:0];
                cbf_pkg::REG_MAX_AREA:     r_cfg.max_area     <= i_cfg_data[cbf_pkg::CFG_AREA_W-1:0];
                cbf_pkg::REG_ROI_LEFT:     r_cfg.roi_left     <= i_cfg_data[cbf_pkg::CFG_DIM_W-1:0];
                cbf_pkg::REG_ROI_TOP:      r_cfg.roi_top      <= i_cfg_data[cbf_pkg::CFG_DIM_W-1:0];
                cbf_pkg::REG_ROI_WIDTH:    r_cfg.roi_width    <= i_cfg_data[cbf_pkg::CFG_DIM_W-1:0];
                cbf_pkg::REG_ROI_HEIGHT:   r_cfg.roi_height   <= i_cfg_data[cbf_pkg::CFG_DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // running extrema; a last point restarts them from the image size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= CW'(cbf_pkg::CFG_RESET.image_width);
            r_min_y <= CW'(cbf_pkg::CFG_RESET.image_height);
            r_max_x <= '0;
            r_max_y <= '0;
        end else if (s_in_beat) begin
            if (i_s_tlast) begin
                r_min_x <= CW'(r_cfg.image_width);
                r_min_y <= CW'(r_cfg.image_height);
                r_max_x <= '0;
                r_max_y <= '0;
            end else begin
                r_min_x <= n_min_x;
                r_min_y <= n_min_y;
                r_max_x <= n_max_x;
                r_max_y <= n_max_y;
            end
        end
    end

    // box datapath: corner, size, area, then one test per cycle
    always_ff @(posedge i_clk) begin
        if (s_in_beat && i_s_tlast) begin
            r_box.x <= n_min_x;
            r_box.y <= n_min_y;
            r_hi_x  <= n_max_x;
            r_hi_y  <= n_max_y;
        end
        if (r_state == cbf_pkg::ST_SIZE) begin
            // minima stay at the image size if every point lay beyond it
            r_box.w <= (r_hi_x >= r_box.x) ? r_hi_x - r_box.x : '0;
            r_box.h <= (r_hi_y >= r_box.y) ? r_hi_y - r_box.y : '0;
        end
        if (r_state == cbf_pkg::ST_AREA) begin
            r_area <= cbf_pkg::AREA_W'(r_box.w) * cbf_pkg::AREA_W'(r_box.h);
        end
        if (r_state == cbf_pkg::ST_CHECK) begin
            if (s_fail) begin
                r_verdict <= cbf_pkg::check_verdict(r_step);
            end else if (s_last_check) begin
                r_verdict <= cbf_pkg::V_KEPT;
            end
        end
    end

    // test index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= cbf_pkg::CK_SMALL;
        end else if (r_state == cbf_pkg::ST_AREA) begin
            r_step <= cbf_pkg::CK_SMALL;
        end else if (r_state == cbf_pkg::ST_CHECK && !s_fail && !s_last_check) begin
            r_step <= cbf_pkg::t_check'(cbf_pkg::CHECK_W'(r_step) + cbf_pkg::CHECK_W'(1));
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_load_out) begin
            r_out_valid <= 1'b1;
        end else if (s_out_beat) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_load_out) begin
            r_out_box     <= r_box;
            r_out_verdict <= r_verdict;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = cbf_pkg::OUT_DATA_W'({r_out_box.h, r_out_box.w,
                                              r_out_box.y, r_out_box.x});
    assign o_m_tuser  = r_out_verdict;

endmodule

FILE: rtl/cbf_judge.sv
// shared compare unit: one box test per cycle, selected by the sequencer
module cbf_judge (
    input  cbf_pkg::t_check i_check,
    input  cbf_pkg::t_box   i_box,
    input  logic [cbf_pkg::AREA_W-1:0] i_area,
    input  cbf_pkg::t_cfg   i_cfg,
    output logic            o_fail
);

    localparam int K_FACTOR = cbf_pkg::ASPECT_LIMIT + 1;

    cbf_pkg::t_cmp s_a;
    cbf_pkg::t_cmp s_b;
    logic          s_inv;
    logic          s_lt;

    // operand select, zero extended into the signed compare width
    always_comb begin
        s_a   = '0;
        s_b   = '0;
        s_inv = 1'b0;
        unique case (i_check)
            cbf_pkg::CK_SMALL: begin
                s_a = cbf_pkg::CMP_W'(i_area);
                s_b = cbf_pkg::CMP_W'(i_cfg.min_area);
            end
            cbf_pkg::CK_LARGE: begin
                s_a = cbf_pkg::CMP_W'(i_cfg.max_area);
                s_b = cbf_pkg::CMP_W'(i_area);
            end
            cbf_pkg::CK_WIDE: begin
                s_a   = cbf_pkg::CMP_W'(i_box.w);
                s_b   = cbf_pkg::CMP_W'(i_box.h) * cbf_pkg::CMP_W'(K_FACTOR);
                s_inv = 1'b1;
            end
            cbf_pkg::CK_TALL: begin
                s_a   = cbf_pkg::CMP_W'(i_box.h);
                s_b   = cbf_pkg::CMP_W'(i_box.w) * cbf_pkg::CMP_W'(K_FACTOR);
                s_inv = 1'b1;
            end
            cbf_pkg::CK_LEFT_EDGE: begin
                s_a   = cbf_pkg::CMP_W'(cbf_pkg::EDGE_MARGIN);
                s_b   = cbf_pkg::CMP_W'(i_box.x);
                s_inv = 1'b1;
            end
            cbf_pkg::CK_TOP_EDGE: begin
                s_a   = cbf_pkg::CMP_W'(cbf_pkg::EDGE_MARGIN);
                s_b   = cbf_pkg::CMP_W'(i_box.y);
                s_inv = 1'b1;
            end
            cbf_pkg::CK_RIGHT_EDGE: begin
                s_a   = cbf_pkg::CMP_W'(i_box.x) + cbf_pkg::CMP_W'(i_box.w);
                s_b   = cbf_pkg::CMP_W'(i_cfg.image_width)
                      - cbf_pkg::CMP_W'(cbf_pkg::EDGE_MARGIN);
                s_inv = 1'b1;
            end
            cbf_pkg::CK_BOTTOM_EDGE: begin
                s_a   = cbf_pkg::CMP_W'(i_box.y) + cbf_pkg::CMP_W'(i_box.h);
                s_b   = cbf_pkg::CMP_W'(i_cfg.image_height)
                      - cbf_pkg::CMP_W'(cbf_pkg::EDGE_MARGIN);
                s_inv = 1'b1;
            end
            cbf_pkg::CK_ROI_LEFT: begin
                s_a = cbf_pkg::CMP_W'(i_box.x);
                s_b = cbf_pkg::CMP_W'(i_cfg.roi_left);
            end
            cbf_pkg::CK_ROI_TOP: begin
                s_a = cbf_pkg::CMP_W'(i_box.y);
                s_b = cbf_pkg::CMP_W'(i_cfg.roi_top);
            end
            cbf_pkg::CK_ROI_RIGHT: begin
                s_a = cbf_pkg::CMP_W'(i_cfg.roi_left) + cbf_pkg::CMP_W'(i_cfg.roi_width);
                s_b = cbf_pkg::CMP_W'(i_box.x) + cbf_pkg::CMP_W'(i_box.w);
            end
            cbf_pkg::CK_ROI_BOTTOM: begin
                s_a = cbf_pkg::CMP_W'(i_cfg.roi_top) + cbf_pkg::CMP_W'(i_cfg.roi_height);
                s_b = cbf_pkg::CMP_W'(i_box.y) + cbf_pkg::CMP_W'(i_box.h);
            end
            default: begin
                s_a = '0;
                s_b = '0;
            end
        endcase
    end

    assign s_lt   = (s_a < s_b);
    assign o_fail = s_lt ^ s_inv;

endmodule

FILE: rtl/cbf_checker.sv
// port-level checks for the contour box filter, bound to the top level
module cbf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_s_tvalid,
    input logic o_s_tready,
    input logic i_s_tlast,
    input logic o_m_tvalid,
    input logic i_m_tready,
    input logic [cbf_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic [cbf_pkg::VERDICT_W-1:0]  o_m_tuser
);

    localparam int CW = cbf_pkg::COORD_BITS;

    // a pending box stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("box beat dropped or changed while stalled");

    // verdict code in range
    a_verdict_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser <= cbf_pkg::V_OUTSIDE))
        else $error("verdict out of range");

    // closing a contour starts the test sequence, no point taken next cycle
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> !o_s_tready)
        else $error("point taken while box under test");

    // a flat box is never kept
    a_flat_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == cbf_pkg::V_KEPT)) |->
        ((o_m_tdata[3*CW-1:2*CW] != '0) && (o_m_tdata[4*CW-1:3*CW] != '0)))
        else $error("flat box kept");

endmodule

bind contour_box_filter cbf_checker u_cbf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
